/* hdl/bba_pkg.sv */
// Shared definitions for the bitmap block allocator: field widths, command,
// status and register codes, and reset values. No dependencies.
package bba_pkg;

  localparam int CMD_W         = 2;
  localparam int OFFSET_W      = 24;
  localparam int REQ_W         = 16;
  localparam int STATUS_W      = 3;
  localparam int INDEX_W       = 8;
  localparam int BLOCK_BYTES_W = 17;
  localparam int RANGE_W       = 9;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int GROUP_W       = 8;

  localparam int DEF_MAX_BLOCKS  = 256;
  localparam int DEF_GUARD_BYTES = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_AGAIN = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BYTES  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_RANGE = 2'd1;

  localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST  = 17'd64;
  localparam logic [RANGE_W-1:0]       BLOCKS_RANGE_RST = 9'd256;

  localparam logic [GROUP_W-1:0] FULL_GROUP = 8'hFF;

endpackage

/* hdl/bba_if.sv */
// Channel interfaces of the bitmap block allocator: request, response and
// configuration write. Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [OFFSET_W-1:0] payload_offset;
  logic [REQ_W-1:0]    request_bytes;

  modport source (output valid, cmd, payload_offset, request_bytes, input ready);
  modport sink   (input valid, cmd, payload_offset, request_bytes, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  block_index;
  logic [OFFSET_W-1:0] result_offset;

  modport source (output valid, status, block_index, result_offset, input ready);
  modport sink   (input valid, status, block_index, result_offset, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bba_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: sequencer, shared add/subtract unit
// and used-bit bitmap. Depends on bba_pkg, bba_if and bba_ram.
//
//   channel  dir  transfer when       payload
//   cfg      in   valid & ready       index, data (ready is always high)
//   req      in   valid & ready       cmd, payload_offset, request_bytes
//   rsp      out  valid & ready       status, block_index, result_offset
//
// One request is worked on at a time; req.ready is high only while idle.
// Multiplies, the range check and division share a single adder: products are
// built by shift-add, one multiplier bit per cycle, and the free path divides
// one quotient bit per cycle. Allocate scans group by group, then multiplies;
// free and resize multiply and check the range, and free then divides. After
// reset the bitmap RAM is cleared one group per cycle (GROUPS groups, 32 by
// default) before the first request is taken. A stalled response sits in the
// output register; a finished request then waits in the done state.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int GUARD_BYTES = DEF_GUARD_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  bba_cfg_if.sink   cfg,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);

  localparam int GROUPS    = (MAX_BLOCKS + GROUP_W - 1) / GROUP_W;
  localparam int GA_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int RANGE_MAX = (1 << RANGE_W) - 1;
  localparam int CAP       = (MAX_BLOCKS > RANGE_MAX) ? RANGE_MAX : MAX_BLOCKS;
  localparam int GRP_W     = RANGE_W - 3;
  localparam int GCNT_W    = RANGE_W - 2;
  localparam int ACC_W     = BLOCK_BYTES_W + RANGE_W + 1;
  localparam int STEP_W    = $clog2(OFFSET_W);
  localparam int BB_W      = BLOCK_BYTES_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AREA_MUL,
    S_RANGE,
    S_DIV,
    S_DIV_CHK,
    S_FREE_CHK,
    S_SCAN_CHK,
    S_OFF_MUL,
    S_OFF_CHK,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [BB_W-1:0]    block_bytes;
  logic [RANGE_W-1:0] blocks_range;

  // Latched request.
  logic [CMD_W-1:0]    cmd_q;
  logic [OFFSET_W-1:0] off_q;
  logic [REQ_W-1:0]    req_q;

  // Shift-add multiplier and restoring divider state.
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    opb;
  logic [RANGE_W-1:0]  mplier;
  logic [BB_W-1:0]     rem;
  logic [OFFSET_W-1:0] dvd;
  logic [RANGE_W-1:0]  quo;
  logic [STEP_W-1:0]   step;

  // Scan state.
  logic [GRP_W-1:0]   grp;
  logic [GROUP_W-1:0] scan_bits;
  logic [2:0]         scan_bit;
  logic [GA_W-1:0]    clr_addr;

  // Pending result.
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;
  logic [OFFSET_W-1:0] res_offset;

  // Bitmap RAM port.
  logic               ram_we;
  logic [GA_W-1:0]    ram_waddr;
  logic [GROUP_W-1:0] ram_wdata;
  logic [GA_W-1:0]    ram_raddr;
  logic [GROUP_W-1:0] ram_rdata;

  // Shared adder.
  logic [ACC_W-1:0] au_a;
  logic [ACC_W-1:0] au_b;
  logic             au_sub;
  logic [ACC_W:0]   au_sum;
  logic             au_carry;

  logic [RANGE_W-1:0] live_cnt;
  logic [RANGE_W:0]   live_round;
  logic [GCNT_W-1:0]  live_groups;
  logic [GRP_W-1:0]   grp_inc;
  logic               grp_last;
  logic [2:0]         fz;
  logic [RANGE_W-1:0] cand_idx;
  logic [BB_W-1:0]    need_bytes;
  logic               fit_fail;
  logic               free_bit;

  function automatic logic [2:0] first_zero(input logic [GROUP_W-1:0] bits);
    logic [2:0] pos;
    pos = 3'd7;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

  bba_ram #(
    .WIDTH (GROUP_W),
    .DEPTH (GROUPS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  // The number of managed blocks is capped by the bitmap size.
  assign live_cnt    = (blocks_range > RANGE_W'(CAP)) ? RANGE_W'(CAP) : blocks_range;
  assign live_round  = {1'b0, live_cnt} + (RANGE_W + 1)'(GROUP_W - 1);
  assign live_groups = live_round[RANGE_W:3];

  assign grp_inc  = grp + GRP_W'(1);
  assign grp_last = ({1'b0, grp} + GCNT_W'(1)) >= live_groups;
  assign fz       = first_zero(ram_rdata);
  assign cand_idx = {grp, fz};

  // Resize fits when the payload plus both guard regions stays within a block.
  assign need_bytes = {1'b0, req_q} + BB_W'(2 * GUARD_BYTES);
  assign fit_fail   = need_bytes > block_bytes;

  assign free_bit = ram_rdata[quo[2:0]];

  // Operand selection for the shared adder. For a subtraction the carry out is
  // set when a >= b.
  always_comb begin
    au_a   = acc;
    au_b   = opb;
    au_sub = 1'b0;
    unique case (state)
      S_RANGE: begin
        au_a   = ACC_W'(off_q);
        au_b   = acc;
        au_sub = 1'b1;
      end
      S_DIV: begin
        au_a   = ACC_W'({rem, dvd[OFFSET_W-1]});
        au_b   = ACC_W'(block_bytes);
        au_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign au_sum   = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (ACC_W + 1)'(au_sub);
  assign au_carry = au_sum[ACC_W];

  // Bitmap RAM control. While idle the read port points at group 0 so that an
  // allocate can inspect it in the cycle after the transfer; during the
  // scan it always points one group ahead.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN_CHK: begin
        ram_raddr = GA_W'(grp_inc);
      end
      S_DIV_CHK: begin
        ram_raddr = GA_W'(quo[RANGE_W-1:3]);
      end
      S_FREE_CHK: begin
        ram_waddr = GA_W'(quo[RANGE_W-1:3]);
        ram_wdata = ram_rdata & ~(GROUP_W'(1) << quo[2:0]);
        ram_we    = free_bit;
      end
      S_OFF_CHK: begin
        ram_waddr = GA_W'(grp);
        ram_wdata = scan_bits | (GROUP_W'(1) << scan_bit);
        ram_we    = (acc[ACC_W-1:OFFSET_W] == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      block_bytes  <= BLOCK_BYTES_RST;
      blocks_range <= BLOCKS_RANGE_RST;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_BLOCK_BYTES:  block_bytes  <= cfg.data[BB_W-1:0];
          REG_BLOCKS_RANGE: blocks_range <= cfg.data[RANGE_W-1:0];
          default: begin
          end
        endcase
      end

      // In the done state the output register is reloaded instead.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end

      unique case (state) inside
        S_CLEAR: begin
          clr_addr <= clr_addr + GA_W'(1);
          if (clr_addr == GA_W'(GROUPS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.cmd;
            off_q      <= req.payload_offset;
            req_q      <= req.request_bytes;
            res_index  <= '0;
            res_offset <= '0;
            case (req.cmd) inside
              CMD_ALLOC: begin
                grp <= '0;
                if (live_groups == '0) begin
                  res_status <= ST_OOM;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_CHK;
                end
              end
              CMD_FREE, CMD_RESIZE: begin
                // Managed area size = live count * block size.
                acc    <= '0;
                opb    <= ACC_W'(block_bytes);
                mplier <= live_cnt;
                state  <= S_AREA_MUL;
              end
              default: begin
                res_status <= ST_MISMATCH;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_AREA_MUL, S_OFF_MUL: begin
          if (mplier == '0) begin
            state <= (state == S_AREA_MUL) ? S_RANGE : S_OFF_CHK;
          end else begin
            if (mplier[0]) begin
              acc <= au_sum[ACC_W-1:0];
            end
            opb    <= opb << 1;
            mplier <= mplier >> 1;
          end
        end

        S_RANGE: begin
          // A carry here means the offset lies at or past the end of the area.
          if (au_carry || (off_q < OFFSET_W'(GUARD_BYTES))) begin
            res_status <= ST_MISMATCH;
            state      <= S_DONE;
          end else if (cmd_q == CMD_FREE) begin
            rem   <= '0;
            dvd   <= off_q - OFFSET_W'(GUARD_BYTES);
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end else if (fit_fail) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            res_offset <= off_q;
            state      <= S_DONE;
          end
        end

        S_DIV: begin
          // Restoring division, one quotient bit per cycle. The quotient is
          // known to be below the live count, so its low bits suffice.
          rem  <= au_carry ? au_sum[BB_W-1:0] : {rem[BB_W-2:0], dvd[OFFSET_W-1]};
          quo  <= {quo[RANGE_W-2:0], au_carry};
          dvd  <= dvd << 1;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(OFFSET_W - 1)) begin
            state <= S_DIV_CHK;
          end
        end

        S_DIV_CHK: begin
          if (rem != '0) begin
            res_status <= ST_CORRUPT;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_CHK;
          end
        end

        S_FREE_CHK: begin
          res_index  <= quo[INDEX_W-1:0];
          res_status <= free_bit ? ST_OK : ST_FREE_AGAIN;
          state      <= S_DONE;
        end

        S_SCAN_CHK: begin
          if (ram_rdata == FULL_GROUP) begin
            if (grp_last) begin
              res_status <= ST_OOM;
              state      <= S_DONE;
            end else begin
              grp <= grp_inc;
            end
          end else if (cand_idx >= live_cnt) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            // Payload offset = index * block size + guard, built in acc.
            scan_bits <= ram_rdata;
            scan_bit  <= fz;
            acc       <= ACC_W'(GUARD_BYTES);
            opb       <= ACC_W'(block_bytes);
            mplier    <= cand_idx;
            state     <= S_OFF_MUL;
          end
        end

        S_OFF_CHK: begin
          // An offset beyond 24 bits cannot be handed out; nothing is marked.
          if (acc[ACC_W-1:OFFSET_W] != '0) begin
            res_status <= ST_OOM;
          end else begin
            res_status <= ST_OK;
            res_index  <= INDEX_W'({grp, scan_bit});
            res_offset <= acc[OFFSET_W-1:0];
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.block_index   <= res_index;
            rsp.result_offset <= res_offset;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/bba_checker.sv */
`timescale 1ns / 100ps
// Response checker for the bitmap block allocator: tracks register writes and
// requests, predicts each response and compares it. Depends on bba_pkg, bba_if.
module bba_checker import bba_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int GUARD_BYTES = DEF_GUARD_BYTES
) (
  input  logic clk,
  input  logic rst,
  bba_cfg_if   cfg,
  bba_req_if   req,
  bba_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);

  localparam int GROUPS = (MAX_BLOCKS + 7) / 8;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] result_offset;
  } alloc_rsp_t;

  logic [GROUP_W-1:0]       used_map [GROUPS];
  logic [BLOCK_BYTES_W-1:0] blk_bytes;
  logic [RANGE_W-1:0]       blk_range;
  alloc_rsp_t               owed_responses [$];
  int                       fail_count = 0;
  int                       owed_count = 0;

  assign errors      = fail_count;
  assign outstanding = owed_count;

  function automatic int live_blocks();
    return (blk_range > MAX_BLOCKS) ? MAX_BLOCKS : int'(blk_range);
  endfunction

  function automatic bit in_area(logic [OFFSET_W-1:0] off);
    longint area;
    area = longint'(live_blocks()) * longint'(blk_bytes);
    return (longint'(off) < area) && (longint'(off) >= GUARD_BYTES);
  endfunction

  // Lowest free block, scanning whole groups; full groups are skipped.
  function automatic alloc_rsp_t model_allocate();
    int                 n;
    int                 b;
    int                 idx;
    longint             off;
    logic [GROUP_W-1:0] bits;
    n = live_blocks();
    for (int g = 0; g < (n + 7) / 8; g++) begin
      bits = used_map[g];
      if (bits == FULL_GROUP) continue;
      b = 0;
      while (b < 7 && bits[b]) b++;
      idx = g * 8 + b;
      if (idx >= n) break;
      off = longint'(idx) * longint'(blk_bytes) + GUARD_BYTES;
      if (off > longint'(OFFSET_MAX)) break;
      used_map[g][b] = 1'b1;
      return '{ST_OK, idx[INDEX_W-1:0], off[OFFSET_W-1:0]};
    end
    return '{ST_OOM, '0, '0};
  endfunction

  function automatic alloc_rsp_t model_free(logic [OFFSET_W-1:0] off);
    longint rel;
    longint idx;
    if (!in_area(off)) return '{ST_MISMATCH, '0, '0};
    rel = longint'(off) - GUARD_BYTES;
    if (rel % longint'(blk_bytes) != 0) return '{ST_CORRUPT, '0, '0};
    idx = rel / longint'(blk_bytes);
    if (idx >= MAX_BLOCKS) return '{ST_MISMATCH, '0, '0};
    if (!used_map[int'(idx >> 3)][int'(idx & 7)])
      return '{ST_FREE_AGAIN, idx[INDEX_W-1:0], '0};
    used_map[int'(idx >> 3)][int'(idx & 7)] = 1'b0;
    return '{ST_OK, idx[INDEX_W-1:0], '0};
  endfunction

  function automatic alloc_rsp_t model_resize(logic [OFFSET_W-1:0] off,
                                              logic [REQ_W-1:0] rq);
    if (!in_area(off)) return '{ST_MISMATCH, '0, '0};
    if (longint'(rq) + 2 * GUARD_BYTES > longint'(blk_bytes)) return '{ST_OOM, '0, '0};
    return '{ST_OK, '0, off};
  endfunction

  function automatic alloc_rsp_t predict_response(logic [CMD_W-1:0] c,
                                                  logic [OFFSET_W-1:0] off,
                                                  logic [REQ_W-1:0] rq);
    case (c)
      CMD_ALLOC:  return model_allocate();
      CMD_FREE:   return model_free(off);
      CMD_RESIZE: return model_resize(off, rq);
      default:    return '{ST_MISMATCH, '0, '0};
    endcase
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (rst) begin
      foreach (used_map[g]) used_map[g] = '0;
      blk_bytes = BLOCK_BYTES_RST;
      blk_range = BLOCKS_RANGE_RST;
      owed_responses.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_BLOCK_BYTES) blk_bytes = cfg.data[BLOCK_BYTES_W-1:0];
        else if (cfg.index == REG_BLOCKS_RANGE) blk_range = cfg.data[RANGE_W-1:0];
      end
      // A response always belongs to an earlier request, so retire it first.
      if (rsp.valid && rsp.ready) begin
        if (owed_responses.size() == 0) begin
          $error("response transfer with no request outstanding, status %0d", rsp.status);
          fail_count++;
        end else begin
          want = owed_responses.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.block_index !== want.block_index) begin
            $error("block_index: expected %0d, actual %0d",
                   want.block_index, rsp.block_index);
            fail_count++;
          end
          if (rsp.result_offset !== want.result_offset) begin
            $error("result_offset: expected %0d, actual %0d",
                   want.result_offset, rsp.result_offset);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready)
        owed_responses.push_back(predict_response(req.cmd, req.payload_offset,
                                                  req.request_bytes));
    end
    owed_count = owed_responses.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the bitmap block allocator testbench: clock, reset, request and
// register stimulus, response back-pressure and verdict. Depends on bba_pkg,
// bba_if, bba_checker and the bitmap_block_allocator RTL.
module testbench import bba_pkg::*; ();

  // Command 3 and register index 3 have no function; both are still driven so
  // that every bit of those fields toggles.
  localparam logic [CMD_W-1:0]      CMD_UNUSED   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  // The slowest request is an allocate that scans all 32 groups and then runs
  // the shift-add multiply, so a settle time longer than such a request covers
  // any work still in flight.
  localparam int SETTLE_CYCLES = 64;
  // Long receiver hold-off that backs the block up into its input.
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst;
  logic hold_off = 1'b0;

  int fail_count;
  int pending;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Stimulus-side copy of the configuration, used to aim offsets at
  // block boundaries; the checker keeps its own copy for prediction.
  int cur_bb = int'(BLOCK_BYTES_RST);
  int cur_cnt = int'(BLOCKS_RANGE_RST);

  bba_cfg_if cfg_ch ();
  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bba_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (fail_count),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response back-pressure. The hold-off flag overrides the random stall so
  // that the output register stays full and the block stops taking requests.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One long hold-off while the sender keeps offering requests. It is timed
  // to land in the first idling mode, where the sender is rarely idle.
  initial begin
    wait (sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit: the expected run stays well inside it even with every allocate
  // scanning the whole bitmap and heavy stalls on both sides, so it only trips
  // on a hang.
  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  // Offers one request and returns at the edge where it transfers. Valid is
  // left high so the next request can follow back to back; an idle gap drops
  // valid first and always lets the clock advance before raising it again.
  task automatic send(input logic [CMD_W-1:0] c, input logic [OFFSET_W-1:0] off,
                      input logic [REQ_W-1:0] rq);
    if (sent < 500) begin
      send_idle_pct  = 18;
      recv_stall_pct = 59;
    end else if (sent < 1000) begin
      send_idle_pct  = 59;
      recv_stall_pct = 18;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid          <= 1'b1;
    req_ch.cmd            <= c;
    req_ch.payload_offset <= off;
    req_ch.request_bytes  <= rq;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Register write; valid stays high so that writes can follow each other,
  // and the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Stops offering requests and waits until every response has come back,
  // then lets the block settle before anything touches the registers.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] slot_payload(int idx);
    longint o;
    o = longint'(idx) * longint'(cur_bb) + DEF_GUARD_BYTES;
    return o[OFFSET_W-1:0];
  endfunction

  // Mostly well-formed traffic: allocates, frees and resizes aimed at real
  // block payload offsets (one block past the end now and then), with request
  // sizes often right at the fit limit. The rest is noise: any command, random
  // offsets and offsets with one bit flipped off a block boundary.
  task automatic send_random(input int alloc_pct);
    int                  pick;
    int                  live;
    int                  rq;
    int                  rest;
    logic [OFFSET_W-1:0] off;
    live = (cur_cnt > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : cur_cnt;
    off  = slot_payload($urandom_range(live, 0));
    pick = $urandom_range(99);
    rest = 100 - alloc_pct;
    if (pick < alloc_pct) begin
      send(CMD_ALLOC, OFFSET_W'($urandom), REQ_W'($urandom));
    end else if (pick < alloc_pct + rest / 2) begin
      send(CMD_FREE, off, REQ_W'($urandom));
    end else if (pick < alloc_pct + (rest * 3) / 4) begin
      if ($urandom_range(1)) begin
        rq = cur_bb - 2 * DEF_GUARD_BYTES + int'($urandom_range(2)) - 1;
        if (rq < 0) rq = 0;
        if (rq > 65535) rq = 65535;
      end else begin
        rq = int'($urandom_range(65535));
      end
      if ($urandom_range(3) == 0) off = off + OFFSET_W'($urandom_range(cur_bb));
      send(CMD_RESIZE, off, REQ_W'(rq));
    end else begin
      if ($urandom_range(1)) off = OFFSET_W'($urandom);
      else off = off ^ (OFFSET_W'(1) << $urandom_range(OFFSET_W - 1));
      send(CMD_W'($urandom), off, REQ_W'($urandom));
    end
  endtask

  // One configuration phase: drain, program both registers (and poke the
  // unmapped index, which must change nothing), then random traffic.
  task automatic run_phase(input int bb, input int cnt, input int n_items,
                           input int alloc_pct);
    drain();
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
    write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(bb));
    write_reg(REG_BLOCKS_RANGE, CFG_DATA_W'(cnt));
    cfg_ch.valid <= 1'b0;
    cur_bb  = bb & 32'h1FFFF;
    cur_cnt = cnt & 32'h1FF;
    repeat (n_items) send_random(alloc_pct);
  endtask

  initial begin
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.cmd            <= CMD_ALLOC;
    req_ch.payload_offset <= '0;
    req_ch.request_bytes  <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_BLOCK_BYTES;
    cfg_ch.data           <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset configuration: 64-byte blocks, 256 of them,
    // so payload offsets are 8, 72, 136, ... and the area ends at 16384.
    send(CMD_ALLOC, '0, '0);
    send(CMD_ALLOC, '1, '1);              // unused fields all ones
    send(CMD_ALLOC, '0, '0);
    send(CMD_FREE, 24'd72, '0);           // frees block 1
    send(CMD_FREE, 24'd72, '0);           // the same block again
    send(CMD_FREE, 24'd73, '0);           // off the block boundary
    send(CMD_FREE, 24'd0, '0);            // inside the first guard
    send(CMD_FREE, 24'd7, '0);
    send(CMD_FREE, 24'd16384, '0);        // just past the managed area
    send(CMD_FREE, 24'd16383, '0);        // last byte, misaligned
    send(CMD_FREE, '1, '0);
    send(CMD_FREE, 24'd16328, '0);        // last block, never allocated
    send(CMD_RESIZE, 24'd8, 16'd48);      // exactly fills the block
    send(CMD_RESIZE, 24'd8, 16'd49);      // one byte too many
    send(CMD_RESIZE, 24'd100, '1);
    send(CMD_RESIZE, 24'd100, '0);        // resize ignores alignment
    send(CMD_RESIZE, 24'd16384, '0);
    send(CMD_RESIZE, 24'd7, '0);
    send(CMD_UNUSED, '1, '1);
    send(CMD_ALLOC, '0, '0);              // reuses the hole at block 1

    // Shrink to the smallest legal block and a single block. Blocks 1 and 2
    // stay marked from before, beyond the new count, and must be left alone.
    drain();
    write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(17));
    write_reg(REG_BLOCKS_RANGE, CFG_DATA_W'(1));
    cfg_ch.valid <= 1'b0;
    cur_bb  = 17;
    cur_cnt = 1;
    send(CMD_ALLOC, '0, '0);              // block 0 still used: out of memory
    send(CMD_FREE, 24'd8, '0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_FREE, 24'd25, '0);           // block 1 lies outside the count
    send(CMD_RESIZE, 24'd8, 16'd1);       // request plus both guards fits

    // Random phases: the low and high extremes, all-ones register data
    // (block count clamps, and offsets soon outgrow 24 bits, so allocate runs
    // out early), zero block size, zero count, then ordinary mixed settings.
    run_phase(17, 1, 80, 40);
    run_phase(65536, 256, 150, 50);
    run_phase(131071, 131071, 250, 80);
    run_phase(0, 5, 40, 40);
    run_phase(100, 0, 40, 40);
    run_phase(BLOCK_BYTES_RST, BLOCKS_RANGE_RST, 200, 45);
    repeat (4) run_phase($urandom_range(300, 17), $urandom_range(64, 1), 170, 45);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
